// ----- sv/tbsr_pkg.sv -----
// Shared types and constants for the timed bit-bang serial receiver.
package tbsr_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned FRAME_W = 10;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IN_DATA_W = 40;  // level + stamp, padded to bytes

  localparam logic [CFG_W-1:0] MIN_GAP_RESET = 16'd62;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [CNT_W-1:0] FRAME_BITS    = 4'd10;

  typedef enum logic [1:0] {
    CMD_DATA     = 2'd0,
    CMD_EE_DATA  = 2'd1,
    CMD_EE_CLOCK = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_BYTE      = 2'd1,
    ST_BAD_START = 2'd2,
    ST_BAD_STOP  = 2'd3
  } status_t;

  typedef enum logic {
    REG_MIN_GAP = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_idx_t;

endpackage

// ----- sv/timed_bitbang_serial_receiver.sv -----
// Top level: timed bit-bang serial receiver (8N1 frames from timed pin writes).
// An accepted input word's result goes to the result register, or to the skid register while that one is held.
// One word per cycle while the skid register is empty; the frame state update is combinational.
// A two-entry output stage (result register plus skid register) keeps input
// ready high while a finished result waits on the output side.
// Reset (rst, synchronous, active high) clears the frame state and output valids,
// and loads min_bit_gap = 62 and frame_timeout = 1000.
module timed_bitbang_serial_receiver
  import tbsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input words
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,   // [0] level, [32:1] cycle_stamp, rest zero
  input  logic [1:0]           s_axis_tuser,   // [1:0] command
  // result words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [BYTE_W-1:0]    m_axis_tdata,   // [7:0] rx_byte
  output logic [1:0]           m_axis_tuser    // [1:0] frame_status
);

  // configuration registers
  logic [CFG_W-1:0] min_bit_gap;
  logic [CFG_W-1:0] frame_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_bit_gap   <= MIN_GAP_RESET;
      frame_timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MIN_GAP: min_bit_gap   <= cfg_data;
        REG_TIMEOUT: frame_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame state
  logic [STAMP_W-1:0] last_write_stamp, last_write_stamp_next;
  logic [FRAME_W-1:0] bit_shift, bit_shift_next;
  logic [CNT_W-1:0]   bit_count, bit_count_next;

  // output stage
  logic              out_valid, skid_valid;
  status_t           out_status, skid_status;
  logic [BYTE_W-1:0] out_byte, skid_byte;

  // unpack the input word
  logic               in_level;
  logic [STAMP_W-1:0] in_stamp;
  cmd_t               in_cmd;
  assign in_level = s_axis_tdata[0];
  assign in_stamp = s_axis_tdata[STAMP_W:1];
  assign in_cmd   = cmd_t'(s_axis_tuser);

  logic accept, drain;
  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign drain         = out_valid && m_axis_tready;

  // Stamp sums are one bit wider so they never wrap.
  logic [STAMP_W:0]   timeout_lim, gap_lim;
  logic               acts, backward, timed_out, sample;
  logic [FRAME_W-1:0] shift_base, shifted;
  logic [CNT_W-1:0]   count_base, count_inc;
  status_t            new_status;
  logic [BYTE_W-1:0]  new_byte;

  always_comb begin
    timeout_lim = {1'b0, last_write_stamp} + {{(STAMP_W+1-CFG_W){1'b0}}, frame_timeout};
    gap_lim     = {1'b0, last_write_stamp} + {{(STAMP_W+1-CFG_W){1'b0}}, min_bit_gap};
    // idle-high writes on the data pin do nothing while no bits are held
    acts      = (in_cmd == CMD_DATA) && !(in_level && (bit_count == '0));
    backward  = in_stamp < last_write_stamp;
    timed_out = {1'b0, in_stamp} > timeout_lim;
    sample    = backward || ({1'b0, in_stamp} >= gap_lim);

    shift_base = (backward || timed_out) ? '0 : bit_shift;
    count_base = (backward || timed_out) ? '0 : bit_count;
    shifted    = {in_level, shift_base[FRAME_W-1:1]};
    count_inc  = count_base + CNT_W'(1);

    last_write_stamp_next = last_write_stamp;
    bit_shift_next        = bit_shift;
    bit_count_next        = bit_count;
    new_status            = ST_NONE;
    new_byte              = '0;

    if (acts) begin
      last_write_stamp_next = in_stamp;
      bit_shift_next        = shift_base;
      bit_count_next        = count_base;
      if (sample) begin
        if (count_inc == FRAME_BITS) begin
          // full frame: stop bit is checked before the start bit
          bit_shift_next = '0;
          bit_count_next = '0;
          priority if (!shifted[FRAME_W-1]) begin
            new_status = ST_BAD_STOP;
          end else if (shifted[0]) begin
            new_status = ST_BAD_START;
          end else begin
            new_status = ST_BYTE;
            new_byte   = shifted[BYTE_W:1];
          end
        end else begin
          bit_shift_next = shifted;
          bit_count_next = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_write_stamp <= '0;
      bit_shift        <= '0;
      bit_count        <= '0;
    end else if (accept) begin
      last_write_stamp <= last_write_stamp_next;
      bit_shift        <= bit_shift_next;
      bit_count        <= bit_count_next;
    end
  end

  // Result register with a skid entry behind it; words leave in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || drain) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept;
      end else begin
        out_valid  <= accept;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || drain) begin
      if (skid_valid) begin
        out_status  <= skid_status;
        out_byte    <= skid_byte;
        skid_status <= new_status;
        skid_byte   <= new_byte;
      end else begin
        out_status <= new_status;
        out_byte   <= new_byte;
      end
    end else if (accept) begin
      skid_status <= new_status;
      skid_byte   <= new_byte;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tuser  = out_status;

endmodule

// ----- sv/tbsr_checker.sv -----
// Port-level checker for the timed bit-bang serial receiver, with its bind.
module tbsr_checker
  import tbsr_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [BYTE_W-1:0]    m_axis_tdata,
  input logic [1:0]           m_axis_tuser
);

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // byte is zero unless a good frame is reported
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_BYTE) |-> (m_axis_tdata == '0))
    else $error("nonzero byte without a good frame");

  // input only stalls when a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // a word taken into an empty output shows up next cycle
  a_pass: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("accepted word produced no result");

endmodule

bind timed_bitbang_serial_receiver tbsr_checker u_tbsr_checker (.*);
